/* rtl/core/srb_pkg.sv */
// Shared types and codes for the sequence reorder buffer.
// No dependencies.
`timescale 1ns / 1ps
package srb_pkg;
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_OLDEST  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_TOO_LATE  = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_BUSY      = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_OK        = 3'd6
  } status_e;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] run;
    logic [63:0] payload;
    logic [15:0] length;
  } entry_t;

  localparam int unsigned EntryW = 128;
endpackage

/* rtl/core/srb_store.sv */
// Slot payload memory and slot occupancy memory, each with a registered read port.
// Depends on srb_pkg.
`timescale 1ns / 1ps
module srb_store #(
  parameter int unsigned AddrW = 10
) (
  input  logic                 clk_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  input  logic                 ent_we_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  srb_pkg::entry_t      ent_wdata_i,
  input  logic                 occ_we_i,
  input  logic                 occ_wdata_i,
  output srb_pkg::entry_t      ent_rdata_o,
  output logic                 occ_rdata_o
);
  import srb_pkg::*;

  entry_t ent_mem [2**AddrW];
  logic   occ_mem [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (ent_we_i) begin
      ent_mem[wr_addr_i] <= ent_wdata_i;
    end
    ent_rdata_o <= ent_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (occ_we_i) begin
      occ_mem[wr_addr_i] <= occ_wdata_i;
    end
    occ_rdata_o <= occ_mem[rd_addr_i];
  end
endmodule

/* rtl/core/sequence_reorder_buffer.sv */
// Top level of the sequence reorder buffer: control sequencer around srb_store.
// Depends on srb_pkg and srb_store.
`timescale 1ns / 1ps
// Usage: drive opcode_i and its operand ports with start_i while busy_o is low;
// the command is taken at that clock edge. Exactly one result comes back per
// command, shown for one cycle with done_o high; the receiver cannot stall it.
// Insert and release pass through S_READ, one slot read of the slot memory with
// its registered read port, then S_EVAL for decision and write-back. Get-oldest
// reads one slot per cycle starting at the slot after the last output (slot 0
// before any output), the gap being the number of empty slots walked. Clear
// sweeps the occupancy memory one slot per cycle.
// After reset the block first runs the same sweep, with busy_o high, before it
// takes a command. The user must write the length limit register with cfg_we_i /
// cfg_wdata_i only while idle; the block does not enforce it. It resets to 5200.
// busy_o is high from acceptance and drops in the cycle in which done_o is high,
// so the next command can be taken at the edge that ends that cycle.
module sequence_reorder_buffer #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] seq_num_i,
  input  logic [15:0] run_num_i,
  input  logic [63:0] payload_i,
  input  logic [15:0] frame_bytes_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_seq_o,
  output logic [15:0] out_run_o,
  output logic [63:0] out_payload_o,
  output logic [15:0] out_length_o,
  output logic [9:0]  gaps_skipped_o,
  output logic [31:0] total_missed_o,
  output logic [10:0] frame_count_o
);
  import srb_pkg::*;

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_SCAN  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [AddrW:0]   steps_q, steps_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [31:0]      missed_q, missed_d;
  logic [31:0]      gaps_q, gaps_d;
  logic             lv_q, lv_d;
  logic [31:0]      lseq_q, lseq_d;
  logic [15:0]      maxb_q;
  op_e              op_q;
  logic [31:0]      seq_q;
  logic [15:0]      run_q, len_q;
  logic [63:0]      pay_q;

  logic             done_d;
  status_e          stat_d;
  entry_t           res_d;
  logic [9:0]       gsat_d;

  logic             ent_we, occ_we, occ_wd;
  entry_t           ent_rd, ent_wd;
  logic             occ_rd;
  logic [AddrW-1:0] rd_addr;

  srb_store #(.AddrW(AddrW)) u_store (
    .clk_i       (clk_i),
    .rd_addr_i   (rd_addr),
    .ent_we_i    (ent_we),
    .wr_addr_i   (addr_q),
    .ent_wdata_i (ent_wd),
    .occ_we_i    (occ_we),
    .occ_wdata_i (occ_wd),
    .ent_rdata_o (ent_rd),
    .occ_rdata_o (occ_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxb_q <= 16'd5200;
    end else if (cfg_we_i) begin
      maxb_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      op_q  <= op_e'(opcode_i);
      seq_q <= seq_num_i;
      run_q <= run_num_i;
      pay_q <= payload_i;
      len_q <= frame_bytes_i;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign ent_wd = '{seq: seq_q, run: run_q, payload: pay_q, length: len_q};

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    steps_d = steps_q;
    count_d = count_q;
    missed_d = missed_q;
    gaps_d  = gaps_q;
    lv_d    = lv_q;
    lseq_d  = lseq_q;
    done_d  = 1'b0;
    stat_d  = ST_OK;
    res_d   = '0;
    gsat_d  = '0;
    ent_we  = 1'b0;
    occ_we  = 1'b0;
    occ_wd  = 1'b0;
    rd_addr = addr_q;
    unique case (state_q)
      S_SWEEP: begin
        occ_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == AddrW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
          if (op_q == OP_CLEAR && steps_q[0]) begin
            done_d = 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (start_i) begin
          gaps_d  = '0;
          steps_d = '0;
          unique case (op_e'(opcode_i))
            OP_CLEAR: begin
              addr_d  = '0;
              count_d = '0;
              lv_d    = 1'b0;
              lseq_d  = '0;
              steps_d = {{AddrW{1'b0}}, 1'b1};
              state_d = S_SWEEP;
            end
            OP_OLDEST: begin
              addr_d  = lv_q ? AddrW'(lseq_q % TABLE_DEPTH) + 1'b1 : '0;
              if (lv_q && AddrW'(lseq_q % TABLE_DEPTH) == AddrW'(TABLE_DEPTH - 1)) begin
                addr_d = '0;
              end
              state_d = S_READ;
            end
            default: begin
              addr_d  = AddrW'(seq_num_i % TABLE_DEPTH);
              state_d = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        state_d = (op_q == OP_OLDEST) ? S_SCAN : S_EVAL;
      end
      S_SCAN: begin
        rd_addr = (addr_q == AddrW'(TABLE_DEPTH - 1)) ? '0 : addr_q + 1'b1;
        if (count_q == '0) begin
          done_d  = 1'b1;
          stat_d  = ST_EMPTY;
          state_d = S_IDLE;
        end else if (occ_rd) begin
          done_d   = 1'b1;
          missed_d = missed_q + gaps_q;
          lv_d     = 1'b1;
          lseq_d   = ent_rd.seq;
          res_d    = ent_rd;
          gsat_d   = (gaps_q > 32'd1023) ? 10'd1023 : gaps_q[9:0];
          state_d  = S_IDLE;
        end else begin
          gaps_d = gaps_q + 1'b1;
          addr_d = rd_addr;
        end
      end
      S_EVAL: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (op_q == OP_RELEASE) begin
          if (occ_rd) begin
            occ_we  = 1'b1;
            count_d = count_q - 1'b1;
          end else begin
            stat_d = ST_EMPTY;
          end
        end else if (len_q > maxb_q) begin
          stat_d = ST_TOO_LARGE;
        end else if (!occ_rd) begin
          occ_we  = 1'b1;
          occ_wd  = 1'b1;
          ent_we  = 1'b1;
          count_d = count_q + 1'b1;
          stat_d  = ST_INSERTED;
        end else if (ent_rd.run != run_q || ent_rd.seq == seq_q) begin
          stat_d = ST_DUPLICATE;
        end else if (lv_q && ((lseq_q - seq_q) > 32'h7FFF_FFFF)) begin
          stat_d = ST_TOO_LATE;
        end else begin
          stat_d = ST_BUSY;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_SWEEP;
      addr_q   <= '0;
      steps_q  <= '0;
      count_q  <= '0;
      missed_q <= '0;
      gaps_q   <= '0;
      lv_q     <= 1'b0;
      lseq_q   <= '0;
      done_o   <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      steps_q  <= steps_d;
      count_q  <= count_d;
      missed_q <= missed_d;
      gaps_q   <= gaps_d;
      lv_q     <= lv_d;
      lseq_q   <= lseq_d;
      done_o   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_o       <= stat_d;
    out_seq_o      <= res_d.seq;
    out_run_o      <= res_d.run;
    out_payload_o  <= res_d.payload;
    out_length_o   <= res_d.length;
    gaps_skipped_o <= gsat_d;
    total_missed_o <= missed_d;
    frame_count_o  <= (CntW > 11 && count_d > 2047) ? 11'd2047 : 11'(count_d);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("command accepted without going busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("occupancy count exceeds table depth");
endmodule
